// ----- src/ffsa_pkg.sv -----
// Shared constants for the first-free-slot allocator.
// Holds payload widths, operation codes and the default slot count.
// No dependencies.
package ffsa_pkg;

	// Payload widths fixed by the interface
	localparam int POS_W  = 11;
	localparam int SLOT_W = 11;

	// Default number of slots in the map
	localparam int SLOTS_DEFAULT = 1024;

	// Operation codes carried on the operation port
	localparam logic OP_CLAIM   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

endpackage

// ----- src/ffsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the summary tree of the first-free-slot allocator.
// No package dependencies.
module ffsa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/first_free_slot_allocator_unit.sv -----
// First-free-slot allocator: top level with sequencer, tree walk and result register.
// Depends on ffsa_pkg (widths, op codes, defaults) and ffsa_ram (summary tree store).
//
//   channel | handshake            | payload            | direction
//   --------+----------------------+--------------------+----------
//   request | req_valid, req_stall | operation,position | in
//   result  | rsp_valid, rsp_stall | slot, found        | out
//
// Sequence: a claim walks up from its start leaf, walks down to the first free leaf, then
//   rewrites the path to the root, one tree entry per cycle through the single RAM read
//   port; its result may then wait for the output register to drain. A release rewrites
//   the path to the root, or is dropped when the slot is already free. Only one request
//   is in the sequencer at a time.
// Reset: after arst_n the tree is rebuilt by a pass over LEAVES-1 entries (SLOTS padded
//   up to a power of two), one entry per cycle; req_stall stays high.
// Stalls: the result sits in an output register; the next request is taken while
//   it waits, and a later result holds in the sequencer until the register drains.
module first_free_slot_allocator_unit #(
	parameter int SLOTS = ffsa_pkg::SLOTS_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       operation,
	input  logic [ffsa_pkg::POS_W-1:0] position,
	// result channel
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [ffsa_pkg::SLOT_W-1:0] slot,
	output logic                       found
);

	// Tree geometry: LEAVES leaves, heap-numbered nodes 1..2*LEAVES-1.
	// RAM entry p holds the pair {bit of node 2p+1, bit of node 2p}.
	localparam int LOG    = $clog2(SLOTS);
	localparam int LEAVES = 1 << LOG;
	localparam int NW     = LOG + 1;
	localparam int PW     = (LOG > ffsa_pkg::POS_W) ? LOG : ffsa_pkg::POS_W;
	localparam int SW     = (NW > ffsa_pkg::SLOT_W) ? NW : ffsa_pkg::SLOT_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_UP    = 3'd2;
	localparam logic [2:0] S_DOWN  = 3'd3;
	localparam logic [2:0] S_REL   = 3'd4;
	localparam logic [2:0] S_UPD   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0]     state_q, state_d;
	logic [NW-1:0]  n_q, n_d;            // current tree node
	logic           first_q, first_d;    // still at leaf level on the way up
	logic           claim_q, claim_d;
	logic           v_q, v_d;            // bit to write on the update path
	logic [LOG-1:0] leaf_q, leaf_d;      // claimed leaf index
	logic           res_found_q, res_found_d;
	logic [ffsa_pkg::SLOT_W-1:0] res_slot_q, res_slot_d;

	// clearing pass
	logic [LOG-1:0] clr_p_q, clr_p_d;
	logic [NW-1:0]  span_q, span_d;
	logic [NW-1:0]  acc_q, acc_d;

	// result register
	logic                        rsp_valid_q;
	logic [ffsa_pkg::SLOT_W-1:0] slot_q;
	logic                        found_q;
	logic                        load_out;

	// RAM port signals
	logic           wr_en;
	logic [LOG-1:0] wr_addr;
	logic [1:0]     wr_data;
	logic [LOG-1:0] rd_addr;
	logic [1:0]     rd_data;

	// request decode
	logic [ffsa_pkg::POS_W-1:0] pos_eff;
	logic [PW-1:0]              pos_ext;
	logic                       in_range;
	logic [NW-1:0]              n_in;

	// walk helpers
	logic          own, sib;
	logic [NW-1:0] n_sib, n_up, n_dn, n_par;
	logic [NW-1:0] acc_span;
	logic [SW-1:0] slot_sum;

	assign pos_eff  = (position == '0) ? ffsa_pkg::POS_W'(1) : position;
	assign pos_ext  = PW'(pos_eff) - PW'(1);
	assign in_range = (32'(pos_eff) <= 32'(SLOTS));
	assign n_in     = {1'b1, pos_ext[LOG-1:0]};

	assign own      = rd_data[n_q[0]];
	assign sib      = rd_data[~n_q[0]];
	assign n_sib    = n_q | NW'(1);
	assign n_up     = n_q >> 1;
	assign n_dn     = {n_q[LOG-1:0], ~rd_data[0]};    // leftmost child with a free slot
	assign n_par    = n_q >> 1;
	assign acc_span = acc_q + span_q;
	assign slot_sum = SW'(leaf_q) + SW'(1);

	always_comb begin
		state_d     = state_q;
		n_d         = n_q;
		first_d     = first_q;
		claim_d     = claim_q;
		v_d         = v_q;
		leaf_d      = leaf_q;
		res_found_d = res_found_q;
		res_slot_d  = res_slot_q;
		clr_p_d     = clr_p_q;
		span_d      = span_q;
		acc_d       = acc_q;
		wr_en       = 1'b0;
		wr_addr     = n_q[LOG:1];
		wr_data     = rd_data;
		rd_addr     = n_q[LOG:1];
		load_out    = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				// Write one entry: a node is free when its first leaf is a real slot
				wr_en   = 1'b1;
				wr_addr = clr_p_q;
				wr_data = {(32'(acc_span) < 32'(SLOTS)), (32'(acc_q) < 32'(SLOTS))};
				if (&clr_p_q) begin
					state_d = S_IDLE;
				end else begin
					clr_p_d = clr_p_q + LOG'(1);
					if ((clr_p_q & (clr_p_q + LOG'(1))) == '0) begin
						// last entry of this level: restart at the next level down
						acc_d  = '0;
						span_d = span_q >> 1;
					end else begin
						acc_d = acc_span + span_q;
					end
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					if (operation == ffsa_pkg::OP_CLAIM) begin
						claim_d = 1'b1;
						if (in_range) begin
							n_d     = n_in;
							first_d = 1'b1;
							v_d     = 1'b0;
							rd_addr = n_in[LOG:1];
							state_d = S_UP;
						end else begin
							res_found_d = 1'b0;
							res_slot_d  = '0;
							state_d     = S_EMIT;
						end
					end else begin
						claim_d = 1'b0;
						if (position != '0 && in_range) begin
							n_d     = n_in;
							v_d     = 1'b1;
							rd_addr = n_in[LOG:1];
							state_d = S_REL;
						end
					end
				end
			end
			S_UP: begin
				priority if (first_q && own) begin
					// start slot itself is free; its pair entry is already read
					leaf_d  = n_q[LOG-1:0];
					state_d = S_UPD;
				end else if (!n_q[0] && sib) begin
					n_d = n_sib;
					if (first_q) begin
						leaf_d  = n_sib[LOG-1:0];
						state_d = S_UPD;
					end else begin
						rd_addr = n_sib[LOG-1:0];
						state_d = S_DOWN;
					end
				end else begin
					if (n_up == NW'(1)) begin
						// reached the root: nothing free at or after start
						res_found_d = 1'b0;
						res_slot_d  = '0;
						state_d     = S_EMIT;
					end else begin
						n_d     = n_up;
						first_d = 1'b0;
						rd_addr = n_up[LOG:1];
					end
				end
			end
			S_DOWN: begin
				n_d = n_dn;
				if (n_dn[LOG]) begin
					// leaf reached; fetch its pair entry for the update walk
					leaf_d  = n_dn[LOG-1:0];
					rd_addr = n_dn[LOG:1];
					state_d = S_UPD;
				end else begin
					rd_addr = n_dn[LOG-1:0];
				end
			end
			S_REL, S_UPD: begin
				if (state_q == S_REL && own) begin
					// slot already free: drop the release
					state_d = S_IDLE;
				end else begin
					// Rewrite this node's bit, carry the OR up to the parent
					wr_en   = 1'b1;
					wr_addr = n_q[LOG:1];
					wr_data = n_q[0] ? {v_q, rd_data[0]} : {rd_data[1], v_q};
					v_d     = v_q | sib;
					state_d = S_UPD;
					if (n_par == NW'(1)) begin
						if (claim_q) begin
							res_found_d = 1'b1;
							res_slot_d  = slot_sum[ffsa_pkg::SLOT_W-1:0];
							state_d     = S_EMIT;
						end else begin
							state_d = S_IDLE;
						end
					end else begin
						n_d     = n_par;
						rd_addr = n_par[LOG:1];
					end
				end
			end
			S_EMIT: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_p_q     <= LOG'(1);
			span_q      <= NW'(LEAVES / 2);
			acc_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_p_q <= clr_p_d;
			span_q  <= span_d;
			acc_q   <= acc_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Walk and payload registers
	always_ff @(posedge clk) begin
		n_q         <= n_d;
		first_q     <= first_d;
		claim_q     <= claim_d;
		v_q         <= v_d;
		leaf_q      <= leaf_d;
		res_found_q <= res_found_d;
		res_slot_q  <= res_slot_d;
		if (load_out) begin
			slot_q  <= res_slot_q;
			found_q <= res_found_q;
		end
	end

	ffsa_ram #(
		.WIDTH(2),
		.DEPTH(LEAVES)
	) u_tree (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign slot      = slot_q;
	assign found     = found_q;

endmodule
